// File: rtl/olte_pkg.sv
// shared types and constants of the ordered list table engine
// no dependencies; imported by the cell, the controller and the top level
`timescale 1ns / 1ps

package olte_pkg;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned POS_W  = 8;

  // operation requested by an input transaction
  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_READ   = 3'd2,
    KIND_FIND   = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANGE    = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_NOTFOUND = 2'd3
  } status_e;

  // what every cell of the row does
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_ROTATE = 2'd1,
    ST_SHIFT  = 2'd2
  } ctrl_state_e;

  // broadcast from the controller to all cells
  typedef struct packed {
    cell_op_e            op;
    logic [POS_W-1:0]    idx;    // zero-based position of insert or delete
    logic [POS_W-1:0]    len;    // current list length, for rotation
    logic [ELEM_W-1:0]   value;  // element written by an insert
  } cell_ctrl_t;

endpackage

// File: rtl/ordered_list_table_engine.sv
// top level of the ordered list table engine: a row of DEPTH element cells
// and the sequencer; depends on olte_pkg, olte_cell and olte_ctrl
`timescale 1ns / 1ps

// usage
// - slave stream carries one operation per transaction: insert, delete,
//   read, find or clear; master stream returns exactly one result each
// - insert, clear, unused kinds and every rejected request are answered at
//   accept: the result sits in the output register the cycle after accept
// - read and find rotate the occupied cells once around the row, one place
//   a cycle, comparing or capturing at cell 0
// - delete rotates like read and then shifts the row down
// - the rotation through the cell row keeps the sequencer busy; the next
//   transaction is taken when the sequencer is idle and the output register
//   is empty or being drained in that same cycle
// - a stalled receiver holds the result in the output register; the block
//   takes no new operation until that result is gone
// - reset empties the list at once (length to zero); element cells are not
//   cleared, since no entry beyond the length is ever read
// - no clearing pass, no configuration registers

module ordered_list_table_engine #(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // kind[2:0], position[10:3], value[42:11], zero fill[47:43]
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[1:0], element[33:2], found_position[41:34], count[49:42],
  // zero fill[55:50]
  output logic [55:0] m_axis_tdata_o
);
  import olte_pkg::*;

  cell_ctrl_t        cell_ctrl;
  logic [ELEM_W-1:0] elems [DEPTH];
  status_e           res_status;
  logic [ELEM_W-1:0] res_element;
  logic [POS_W-1:0]  res_fpos;
  logic [POS_W-1:0]  res_count;

  // row of cells; each cell sees its lower and upper neighbor and the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_W-1:0] prev_elem;
    logic [ELEM_W-1:0] next_elem;
    if (i == 0) begin : g_first
      assign prev_elem = elems[0];
    end else begin : g_mid_lo
      assign prev_elem = elems[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_elem = elems[DEPTH-1];
    end else begin : g_mid_hi
      assign next_elem = elems[i+1];
    end
    olte_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .prev_i (prev_elem),
      .next_i (next_elem),
      .head_i (elems[0]),
      .elem_o (elems[i])
    );
  end

  // sequencer with length register and output register
  olte_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .kind_i        (s_axis_tdata_i[2:0]),
    .position_i    (s_axis_tdata_i[10:3]),
    .value_i       (s_axis_tdata_i[42:11]),
    .head_i        (elems[0]),
    .ctrl_o        (cell_ctrl),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_status_o  (res_status),
    .out_element_o (res_element),
    .out_fpos_o    (res_fpos),
    .out_count_o   (res_count)
  );

  assign m_axis_tdata_o = {6'd0, res_count, res_fpos, res_element, res_status};

  // the list never grows past its capacity
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res_count <= POS_W'(DEPTH)))
    else $error("result count above DEPTH");

  // a full report only comes from a list at capacity
  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res_status == STATUS_FULL) |-> (res_count == POS_W'(DEPTH)))
    else $error("full status with list not at capacity");

  // failed requests carry no element and no position
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res_status != STATUS_OK) |-> (res_element == '0 && res_fpos == '0))
    else $error("failed request with nonzero payload");

  // a new operation is never taken while the cells are still rotating
  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_ctrl.op == CELL_ROTATE) |-> !s_axis_tready_o)
    else $error("input accepted during rotation");

endmodule

// File: rtl/olte_cell.sv
// one list cell: holds a single element and takes a new one from a neighbor, the head or the insert value
// depends on olte_pkg
`timescale 1ns / 1ps

module olte_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                       clk_i,
  input  olte_pkg::cell_ctrl_t       ctrl_i,
  input  logic [olte_pkg::ELEM_W-1:0] prev_i,
  input  logic [olte_pkg::ELEM_W-1:0] next_i,
  input  logic [olte_pkg::ELEM_W-1:0] head_i,
  output logic [olte_pkg::ELEM_W-1:0] elem_o
);
  import olte_pkg::*;

  localparam logic [POS_W-1:0] IdxB  = POS_W'(IDX);
  localparam logic [POS_W:0]   IdxUp = (POS_W+1)'(IDX + 1);

  logic [ELEM_W-1:0] elem_q, elem_d;
  logic [POS_W:0]    len_ext;

  assign len_ext = {1'b0, ctrl_i.len};

  always_comb begin
    elem_d = elem_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (IdxB == ctrl_i.idx) begin
          elem_d = ctrl_i.value;
        end else if (IdxB > ctrl_i.idx) begin
          elem_d = prev_i;
        end
      end
      CELL_DELETE: begin
        if (IdxB >= ctrl_i.idx) begin
          elem_d = next_i;
        end
      end
      CELL_ROTATE: begin
        // rotate the occupied cells one place toward the head
        if (IdxUp < len_ext) begin
          elem_d = next_i;
        end else if (IdxUp == len_ext) begin
          elem_d = head_i;
        end
      end
      default: elem_d = elem_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  assign elem_o = elem_q;

endmodule

// File: rtl/olte_ctrl.sv
// sequencer of the list engine: decodes operations, runs rotations, holds
// the length and the output register; depends on olte_pkg
`timescale 1ns / 1ps

module olte_ctrl #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  kind_i,
  input  logic [olte_pkg::POS_W-1:0]  position_i,
  input  logic [olte_pkg::ELEM_W-1:0] value_i,
  input  logic [olte_pkg::ELEM_W-1:0] head_i,
  output olte_pkg::cell_ctrl_t        ctrl_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output olte_pkg::status_e           out_status_o,
  output logic [olte_pkg::ELEM_W-1:0] out_element_o,
  output logic [olte_pkg::POS_W-1:0]  out_fpos_o,
  output logic [olte_pkg::POS_W-1:0]  out_count_o
);
  import olte_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);

  ctrl_state_e       state_q, state_d;
  logic [LW-1:0]     len_q, len_d;
  logic [IW-1:0]     step_q, step_d;
  kind_e             kind_q, kind_d;
  logic [IW-1:0]     pidx_q, pidx_d;
  logic [ELEM_W-1:0] value_q, value_d;
  logic [ELEM_W-1:0] cap_q, cap_d;
  logic              found_q, found_d;
  logic [POS_W-1:0]  fpos_q, fpos_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [ELEM_W-1:0] out_element_q, out_element_d;
  logic [POS_W-1:0]  out_fpos_q, out_fpos_d;
  logic [POS_W-1:0]  out_count_q;

  logic              load;
  logic              accept;
  kind_e             kind_in;
  logic [POS_W:0]    pos_ext;
  logic [POS_W:0]    len_ext;
  logic [POS_W-1:0]  step_up;
  logic              last_step;

  assign kind_in    = kind_e'(kind_i);
  assign pos_ext    = {1'b0, position_i};
  assign len_ext    = (POS_W+1)'(len_q);
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign step_up    = POS_W'(step_q) + POS_W'(1);
  assign last_step  = (LW'(step_q) + LW'(1)) == len_q;

  always_comb begin
    state_d       = state_q;
    len_d         = len_q;
    step_d        = step_q;
    kind_d        = kind_q;
    pidx_d        = pidx_q;
    value_d       = value_q;
    cap_d         = cap_q;
    found_d       = found_q;
    fpos_d        = fpos_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_status_d  = out_status_q;
    out_element_d = out_element_q;
    out_fpos_d    = out_fpos_q;
    load          = 1'b0;
    ctrl_o.op     = CELL_HOLD;
    ctrl_o.idx    = POS_W'(pidx_q);
    ctrl_o.len    = POS_W'(len_q);
    ctrl_o.value  = value_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          kind_d        = kind_in;
          pidx_d        = IW'(position_i - POS_W'(1));
          value_d       = value_i;
          step_d        = '0;
          found_d       = 1'b0;
          fpos_d        = '0;
          out_status_d  = STATUS_OK;
          out_element_d = '0;
          out_fpos_d    = '0;
          case (kind_in)
            KIND_INSERT: begin
              load = 1'b1;
              if (position_i == '0 || pos_ext > len_ext + (POS_W+1)'(1)) begin
                out_status_d = STATUS_RANGE;
              end else if (len_q == LW'(DEPTH)) begin
                out_status_d = STATUS_FULL;
              end else begin
                ctrl_o.op  = CELL_INSERT;
                ctrl_o.idx = position_i - POS_W'(1);
                len_d      = len_q + LW'(1);
              end
            end
            KIND_DELETE, KIND_READ: begin
              if (position_i == '0 || pos_ext > len_ext) begin
                load         = 1'b1;
                out_status_d = STATUS_RANGE;
              end else begin
                state_d = ST_ROTATE;
              end
            end
            KIND_FIND: begin
              if (len_q == '0) begin
                load         = 1'b1;
                out_status_d = STATUS_NOTFOUND;
              end else begin
                state_d = ST_ROTATE;
              end
            end
            KIND_CLEAR: begin
              load  = 1'b1;
              len_d = '0;
            end
            default: load = 1'b1;
          endcase
        end
      end
      ST_ROTATE: begin
        // cell 0 holds the element at list index step_q in this cycle
        ctrl_o.op = CELL_ROTATE;
        step_d    = step_q + IW'(1);
        if (kind_q == KIND_FIND) begin
          if (!found_q && head_i == value_q) begin
            found_d = 1'b1;
            fpos_d  = step_up;
          end
        end else if (step_q == pidx_q) begin
          cap_d = head_i;
        end
        if (last_step) begin
          if (kind_q == KIND_DELETE) begin
            state_d = ST_SHIFT;
          end else begin
            state_d       = ST_IDLE;
            load          = 1'b1;
            out_status_d  = STATUS_OK;
            out_element_d = '0;
            out_fpos_d    = '0;
            if (kind_q == KIND_FIND) begin
              if (found_d) begin
                out_fpos_d = fpos_d;
              end else begin
                out_status_d = STATUS_NOTFOUND;
              end
            end else begin
              out_element_d = cap_d;
            end
          end
        end
      end
      ST_SHIFT: begin
        ctrl_o.op     = CELL_DELETE;
        len_d         = len_q - LW'(1);
        state_d       = ST_IDLE;
        load          = 1'b1;
        out_status_d  = STATUS_OK;
        out_element_d = cap_q;
        out_fpos_d    = '0;
      end
      default: state_d = ST_IDLE;
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      step_q      <= '0;
      kind_q      <= KIND_CLEAR;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      step_q      <= step_d;
      kind_q      <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q        <= pidx_d;
    value_q       <= value_d;
    cap_q         <= cap_d;
    fpos_q        <= fpos_d;
    out_status_q  <= out_status_d;
    out_element_q <= out_element_d;
    out_fpos_q    <= out_fpos_d;
    if (load) begin
      out_count_q <= POS_W'(len_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_element_o = out_element_q;
  assign out_fpos_o    = out_fpos_q;
  assign out_count_o   = out_count_q;

endmodule

// File: dv/olte_list_checker.sv
// checker for the ordered list table engine: watches both stream channels,
// predicts each result from a private copy of the list and compares them
// depends on olte_pkg for the operation and status codes
`timescale 1ns / 1ps

module olte_list_checker #(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [47:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [55:0] m_axis_tdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  import olte_pkg::*;

  typedef struct {
    status_e            status;
    logic signed [31:0] element;
    logic [7:0]         found_pos;
    logic [7:0]         count;
  } list_result_t;

  // shadow of the list held by the block
  logic [31:0]  list_mem [DEPTH];
  int           list_len;
  list_result_t expected_results [$];
  list_result_t want;
  list_result_t got;

  // applies one operation to the shadow list and returns its result
  function automatic list_result_t apply_list_op(logic [2:0] kind, logic [7:0] pos,
                                                 logic [31:0] value);
    list_result_t r;
    int k;
    int p;
    r.status    = STATUS_OK;
    r.element   = '0;
    r.found_pos = '0;
    p = pos;
    case (kind)
      KIND_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          r.status = STATUS_RANGE;
        end else if (list_len >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          for (k = list_len; k >= p; k--) list_mem[k] = list_mem[k-1];
          list_mem[p-1] = value;
          list_len++;
        end
      end
      KIND_DELETE: begin
        if (p < 1 || p > list_len) begin
          r.status = STATUS_RANGE;
        end else begin
          r.element = list_mem[p-1];
          for (k = p; k < list_len; k++) list_mem[k-1] = list_mem[k];
          list_len--;
        end
      end
      KIND_READ: begin
        if (p < 1 || p > list_len) r.status = STATUS_RANGE;
        else r.element = list_mem[p-1];
      end
      KIND_FIND: begin
        // first match wins, only occupied entries are searched
        r.status = STATUS_NOTFOUND;
        for (k = 0; k < list_len; k++) begin
          if (r.status == STATUS_NOTFOUND && list_mem[k] == value) begin
            r.status    = STATUS_OK;
            r.found_pos = 8'(k + 1);
          end
        end
      end
      KIND_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count = 8'(list_len);
    return r;
  endfunction

  task automatic report_field(string field, longint exp_val, longint act_val);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, act_val);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len     = 0;
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      // results leave in a later cycle than their request, so compare first
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.status    = status_e'(m_axis_tdata_i[1:0]);
        got.element   = m_axis_tdata_i[33:2];
        got.found_pos = m_axis_tdata_i[41:34];
        got.count     = m_axis_tdata_i[49:42];
        checked_o++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction, status %0d element %0d count %0d",
                   $time, got.status, got.element, got.count);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_field("status", want.status, got.status);
          if (got.element !== want.element)
            report_field("element", want.element, got.element);
          if (got.found_pos !== want.found_pos)
            report_field("found_position", want.found_pos, got.found_pos);
          if (got.count !== want.count)
            report_field("count", want.count, got.count);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_results.push_back(apply_list_op(s_axis_tdata_i[2:0], s_axis_tdata_i[10:3],
                                                 s_axis_tdata_i[42:11]));
      pending_o = expected_results.size();
    end
  end

endmodule

// File: dv/tb_top.sv
// top of the ordered list table engine testbench: clock, reset, stimulus
// and verdict; depends on olte_pkg, olte_list_checker and the block itself
`timescale 1ns / 1ps

module tb_top;
  import olte_pkg::*;

  localparam int unsigned DEPTH       = 8;
  localparam int          RANDOM_OPS  = 1000;
  localparam int          CYCLE_LIMIT = 200000;
  // kind codes the block must answer without touching the list
  localparam logic [2:0]  KIND_SPARE_5 = 3'd5;
  localparam logic [2:0]  KIND_SPARE_6 = 3'd6;
  localparam logic [2:0]  KIND_SPARE_7 = 3'd7;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // kind[2:0], position[10:3], value[42:11], zero fill[47:43]
  logic [47:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // status[1:0], element[33:2], found_position[41:34], count[49:42], zero fill[55:50]
  logic [55:0] m_axis_tdata_o;

  int fail_count;
  int pending_results;
  int results_checked;
  int cycle_count = 0;
  int kind_hits [8];
  bit idle_enable = 1'b1;

  always #5 clk_i = ~clk_i;

  ordered_list_table_engine #(.DEPTH(DEPTH)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  olte_list_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_results),
    .checked_o       (results_checked)
  );

  // result receiver: stalls at random, with a chance of 11 in a hundred, unless idling is off
  always @(negedge clk_i) begin
    m_axis_tready_i <= !(idle_enable && $urandom_range(99) < 11);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results);
      $display("FAILURE");
      $finish;
    end
  end

  // one request transaction; called and left at a falling edge
  task automatic send_op(logic [2:0] kind, logic [7:0] pos, logic [31:0] value);
    if (idle_enable && $urandom_range(99) < 11) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {5'b0, value, pos, kind};
    kind_hits[kind]++;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // sender holds off until every pending result has been checked
  task automatic drain_results();
    s_axis_tvalid_i = 1'b0;
    while (pending_results != 0) @(negedge clk_i);
  endtask

  // random request: mostly positions from 1 to DEPTH + 1, and half the time a small
  // value pool so that finds hit and duplicate entries show up
  task automatic send_random_op();
    logic [2:0]  kind;
    logic [7:0]  pos;
    logic [31:0] value;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 32)      kind = KIND_INSERT;
    else if (pick < 52) kind = KIND_DELETE;
    else if (pick < 70) kind = KIND_READ;
    else if (pick < 90) kind = KIND_FIND;
    else if (pick < 94) kind = KIND_CLEAR;
    else                kind = 3'($urandom_range(KIND_SPARE_5, KIND_SPARE_7));
    pick = $urandom_range(99);
    if (pick < 85)      pos = 8'($urandom_range(1, DEPTH + 1));
    else if (pick < 90) pos = 8'd0;
    else                pos = 8'($urandom_range(0, 255));
    if ($urandom_range(1)) value = 32'($signed($urandom_range(0, 7)) - 4);
    else                   value = $urandom;
    send_op(kind, pos, value);
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty list rejections
    send_op(KIND_READ,   8'd1,   32'd0);
    send_op(KIND_DELETE, 8'd0,   32'd0);
    send_op(KIND_FIND,   8'd0,   32'd0);
    send_op(KIND_INSERT, 8'd0,   32'd7);
    send_op(KIND_INSERT, 8'd2,   32'd7);
    // fill to full: head, tail and middle inserts with extreme values
    send_op(KIND_INSERT, 8'd1,   32'h8000_0000);
    send_op(KIND_INSERT, 8'd1,   32'h7fff_ffff);
    send_op(KIND_INSERT, 8'd3,   32'hffff_ffff);
    send_op(KIND_INSERT, 8'd2,   32'h0000_0000);
    send_op(KIND_INSERT, 8'd5,   32'h5555_5555);
    send_op(KIND_INSERT, 8'd1,   32'haaaa_aaaa);
    send_op(KIND_INSERT, 8'd4,   32'hffff_ffff);
    send_op(KIND_INSERT, 8'd8,   32'd1);
    // full list: a valid position reports full, a bad one reports range
    send_op(KIND_INSERT, 8'd9,   32'd2);
    send_op(KIND_INSERT, 8'd255, 32'd2);
    // find with duplicates present, and a miss
    send_op(KIND_FIND,   8'd0,   32'hffff_ffff);
    send_op(KIND_FIND,   8'd255, 32'd12345);
    send_op(KIND_READ,   8'd8,   32'd0);
    send_op(KIND_READ,   8'd9,   32'd0);
    send_op(KIND_READ,   8'd255, 32'd0);
    send_op(KIND_DELETE, 8'd8,   32'd0);
    send_op(KIND_DELETE, 8'd1,   32'd0);
    send_op(KIND_SPARE_5, 8'd1,  32'd0);
    send_op(KIND_SPARE_7, 8'd255, 32'hffff_ffff);
    send_op(KIND_CLEAR,  8'd3,   32'd0);

    // the block is known idle here at least once
    drain_results();

    for (int i = 0; i < RANDOM_OPS; i++) begin
      // one long stretch with both sides running flat out
      idle_enable = !(i >= 400 && i < 600);
      if (i % 250 == 249) drain_results();
      send_random_op();
    end

    drain_results();
    repeat (20) @(negedge clk_i);

    $display("covered %0d requests: insert %0d, delete %0d, read %0d, find %0d, clear %0d,",
             kind_hits.sum(), kind_hits[KIND_INSERT], kind_hits[KIND_DELETE],
             kind_hits[KIND_READ], kind_hits[KIND_FIND], kind_hits[KIND_CLEAR]);
    $display("unused kinds %0d; %0d results checked, %0d mismatches",
             kind_hits[KIND_SPARE_5] + kind_hits[KIND_SPARE_6] + kind_hits[KIND_SPARE_7],
             results_checked, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
